@@ hdl/s256_pkg.sv @@
package s256_pkg;

	localparam int WORD_W   = 32;
	localparam int HASH_N   = 8;
	localparam int HADDR_W  = 3;
	localparam int SCHED_N  = 16;
	localparam int ROUND_N  = 64;
	localparam int RIDX_W   = 6;
	localparam int FILL_W   = 6;
	localparam int LEN_W    = 64;
	localparam int BYTE_W   = 8;
	localparam int OUT_TDATA_W = 40;

	localparam logic [BYTE_W-1:0]  PAD_MARK      = 8'h80;
	localparam logic [FILL_W-1:0]  LEN_START     = 6'd56;
	localparam logic [FILL_W-1:0]  BLOCK_LAST    = 6'd63;
	localparam logic [HADDR_W-1:0] LAST_WORD_IDX = 3'd7;

	localparam logic [WORD_W-1:0] ROUND_K [ROUND_N] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WORD_W-1:0] INIT_HASH [HASH_N] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Hash memory request: one read and one write port, plus a bulk restore
	typedef struct packed {
		logic               rd_en;
		logic [HADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [HADDR_W-1:0] wr_addr;
		logic               restore;
	} ram_req_t;

	// Round datapath control
	typedef struct packed {
		logic              w_push;
		logic              wv_load;
		logic              round_en;
		logic              wv_rotate;
		logic [RIDX_W-1:0] round_idx;
	} core_ctrl_t;

endpackage

@@ hdl/s256_hash_ram.sv @@
module s256_hash_ram
	import s256_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ram_req_t          req,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0]  mem [HASH_N];
	logic [HASH_N-1:0]  valid_q;
	logic [WORD_W-1:0]  data_s1;
	logic               valid_s1;
	logic [HADDR_W-1:0] addr_s1;

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
	end

	// Track written entries; an unwritten entry reads as the initial hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.restore) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			data_s1  <= mem[req.rd_addr];
			valid_s1 <= valid_q[req.rd_addr];
			addr_s1  <= req.rd_addr;
		end
	end

	assign rd_data = valid_s1 ? data_s1 : INIT_HASH[addr_s1];

endmodule

@@ hdl/s256_round_core.sv @@
module s256_round_core
	import s256_pkg::*;
(
	input  logic              clk,
	input  core_ctrl_t        ctrl,
	input  logic [WORD_W-1:0] w_word,
	input  logic [WORD_W-1:0] load_word,
	output logic [WORD_W-1:0] wv_head
);

	logic [WORD_W-1:0] wv_q [HASH_N];
	logic [WORD_W-1:0] w_q  [SCHED_N];
	logic [WORD_W-1:0] sched_new;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
		rotr = (v >> n) | (v << (WORD_W - n));
	endfunction

	// Next schedule word and round sums
	always_comb begin
		sched_new = w_q[0]
			+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[9]
			+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
		t1 = wv_q[7]
			+ (rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25))
			+ ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
			+ ROUND_K[ctrl.round_idx]
			+ w_q[0];
		t2 = (rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22))
			+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	// Message words: fill from the byte packer, advance one per round
	always_ff @(posedge clk) begin
		if (ctrl.w_push || ctrl.round_en) begin
			for (int j = 0; j < SCHED_N - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[SCHED_N-1] <= ctrl.round_en ? sched_new : w_word;
		end
	end

	// Working words a..h: load, round, or rotate past the hash update
	always_ff @(posedge clk) begin
		if (ctrl.wv_load || ctrl.wv_rotate) begin
			for (int j = 0; j < HASH_N - 1; j++) begin
				wv_q[j] <= wv_q[j+1];
			end
			wv_q[HASH_N-1] <= ctrl.wv_load ? load_word : wv_q[0];
		end else if (ctrl.round_en) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	assign wv_head = wv_q[0];

endmodule

@@ hdl/sha256_message_digest.sv @@
// SHA-256 digest engine, one message byte per request.
// Input channel s_*: s_tdata carries the byte, s_tuser[0] says the byte is
// part of the message, s_tlast ends the message (an empty message is fine).
// A request with neither a byte nor an end mark is taken and ignored.
// Output channel m_*: eight requests per message, digest words h0..h7,
// word index in m_tdata[34:32], m_tlast on h7.
// Bytes are taken one per cycle while s_tready is high. The 64th byte of a
// block starts a compression (loading the hash words from the hash memory
// over its single read port, 64 rounds, writing the sums back), during which
// s_tready is low. An end mark adds padding bytes up to the end of the final
// block (9 to 72 bytes, two blocks when fewer than nine bytes are free), one
// or two compressions, and then reads each digest word from the hash memory
// and holds it until the receiver takes it.
// Sustained throughput is set by the one-round-per-cycle loop and the serial
// hash memory port.
// A stalled m_tready holds the current word and the block takes no input
// until all eight words are gone; it then restores the initial hash.
// Reset clears the byte count, bit length and restores the initial hash.
module sha256_message_digest
	import s256_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
	input  logic [0:0]             s_tuser,   // [0] has_byte
	input  logic                   s_tlast,   // end_of_message
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic                   m_tlast    // last_word
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_LOAD    = 8'b0000_0010,
		ST_ROUND   = 8'b0000_0100,
		ST_UPDATE  = 8'b0000_1000,
		ST_PAD     = 8'b0001_0000,
		ST_EMIT_RD = 8'b0010_0000,
		ST_EMIT_LD = 8'b0100_0000,
		ST_EMIT_WT = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [FILL_W-1:0]  fill_q;
	logic [LEN_W-1:0]   bit_len_q;
	logic [23:0]        acc_q;
	logic [RIDX_W-1:0]  cnt_q;
	logic [HADDR_W-1:0] emit_idx_q;
	logic               fin_q;
	logic               mark_q;
	logic               final_q;
	logic [WORD_W-1:0]  out_data_q;
	logic [HADDR_W-1:0] out_idx_q;
	logic               out_valid_q;

	logic               accept;
	logic               put_en;
	logic [BYTE_W-1:0]  put_byte;
	logic [BYTE_W-1:0]  pad_byte;
	logic [2:0]         len_sel;
	logic               seq_end;
	ram_req_t           ram_req;
	core_ctrl_t         core_ctrl;
	logic [WORD_W-1:0]  ram_rd_data;
	logic [WORD_W-1:0]  wv_head;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Pick the padding byte: marker, zeros, then the big-endian bit length
	always_comb begin
		len_sel = 3'd7 - fill_q[2:0];
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (!final_q || fill_q < LEN_START) begin
			pad_byte = '0;
		end else begin
			pad_byte = bit_len_q[{len_sel, 3'b000} +: BYTE_W];
		end
	end

	assign put_en   = (accept && s_tuser[0]) || (state_q == ST_PAD);
	assign put_byte = (state_q == ST_PAD) ? pad_byte : s_tdata;
	assign seq_end  = (cnt_q == RIDX_W'(HASH_N));

	// Drive the hash memory and the round datapath
	always_comb begin
		ram_req   = '0;
		core_ctrl = '0;
		core_ctrl.round_idx = cnt_q;
		core_ctrl.w_push    = put_en && (fill_q[1:0] == 2'd3);
		case (state_q)
			ST_LOAD: begin
				ram_req.rd_en     = !cnt_q[3];
				ram_req.rd_addr   = cnt_q[HADDR_W-1:0];
				core_ctrl.wv_load = (cnt_q != '0);
			end
			ST_ROUND: begin
				core_ctrl.round_en = 1'b1;
			end
			ST_UPDATE: begin
				ram_req.rd_en       = !cnt_q[3];
				ram_req.rd_addr     = cnt_q[HADDR_W-1:0];
				ram_req.wr_en       = (cnt_q != '0);
				ram_req.wr_addr     = HADDR_W'(cnt_q - 6'd1);
				core_ctrl.wv_rotate = (cnt_q != '0);
			end
			ST_EMIT_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = emit_idx_q;
			end
			ST_EMIT_WT: begin
				ram_req.restore = m_tready && (emit_idx_q == LAST_WORD_IDX);
			end
			default: begin
			end
		endcase
	end

	// Sequence byte intake, padding, compression and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bit_len_q   <= '0;
			cnt_q       <= '0;
			emit_idx_q  <= '0;
			fin_q       <= 1'b0;
			mark_q      <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mark_q  <= 1'b0;
						final_q <= 1'b0;
						fin_q   <= s_tlast;
						cnt_q   <= '0;
						if (s_tuser[0]) begin
							bit_len_q <= bit_len_q + LEN_W'(8);
						end
						if (s_tuser[0] && fill_q == BLOCK_LAST) begin
							state_q <= ST_LOAD;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					// A block with room left for the length is the last one
					if (fill_q < LEN_START) begin
						final_q <= 1'b1;
					end
					if (fill_q == BLOCK_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (seq_end) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == RIDX_W'(ROUND_N - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (seq_end) begin
						cnt_q <= '0;
						if (final_q) begin
							emit_idx_q <= '0;
							state_q    <= ST_EMIT_RD;
						end else if (fin_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_WT;
				end
				ST_EMIT_WT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (emit_idx_q == LAST_WORD_IDX) begin
							fin_q     <= 1'b0;
							final_q   <= 1'b0;
							bit_len_q <= '0;
							fill_q    <= '0;
							state_q   <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 3'd1;
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pack bytes big-endian into words
	always_ff @(posedge clk) begin
		if (put_en) begin
			acc_q <= {acc_q[15:0], put_byte};
		end
	end

	// Hold the outgoing digest word
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_data_q <= ram_rd_data;
			out_idx_q  <= emit_idx_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_idx_q, out_data_q};
	assign m_tlast  = (out_idx_q == LAST_WORD_IDX);

	s256_hash_ram u_hash_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.wr_data (ram_rd_data + wv_head),
		.rd_data (ram_rd_data)
	);

	s256_round_core u_round_core (
		.clk       (clk),
		.ctrl      (core_ctrl),
		.w_word    ({acc_q, put_byte}),
		.load_word (ram_rd_data),
		.wv_head   (wv_head)
	);

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import s256_pkg::*;

	localparam int RANDOM_ITEMS  = 330;
	localparam int RX_HOLD_CYCLES = 800;
	localparam int TAIL_CYCLES   = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DIRECTED_N    = 14;

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	typedef struct packed {
		logic [7:0]   data;
		logic         has_byte;
		logic         end_mark;
		logic         known;
		logic [255:0] digest;
	} msg_request_t;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  pos;
		logic        is_last;
	} digest_word_t;

	// Directed requests: idle, empty message, "abc", ignored bits, byte extremes
	localparam msg_request_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{8'h00, 1'b0, 1'b0, 1'b0, 256'd0},
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h61, 1'b1, 1'b0, 1'b0, 256'd0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 256'd0},
		'{8'hff, 1'b0, 1'b0, 1'b0, 256'd0},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		'{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h00, 1'b1, 1'b0, 1'b0, 256'd0},
		'{8'hff, 1'b1, 1'b0, 1'b0, 256'd0},
		'{8'h80, 1'b1, 1'b0, 1'b0, 256'd0},
		'{8'h7f, 1'b1, 1'b0, 1'b0, 256'd0},
		'{8'h5a, 1'b0, 1'b1, 1'b0, 256'd0},
		'{8'h01, 1'b1, 1'b1, 1'b0, 256'd0},
		'{8'hff, 1'b1, 1'b1, 1'b0, 256'd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata;
	logic [0:0]             s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	// Hash model state
	logic [31:0] msg_block [16];
	logic [5:0]  msg_fill;
	logic [31:0] run_hash [8];
	logic [63:0] msg_bits;
	logic [31:0] last_digest [8];

	digest_word_t digest_words_due [$];

	int fail_count;
	int cycle_count;
	int words_seen;
	int n_messages;
	int n_bytes;
	int n_idle;
	int cur_len;
	int longest_msg;
	int tx_burst_left;
	bit tx_offering;
	bit rx_hold_req;

	sha256_message_digest DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// Run the 64 rounds over the current block and fold into the hash
	function automatic void sha_round_block();
		logic [31:0] sched_w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		int t;
		for (t = 0; t < 16; t++)
			sched_w[t] = msg_block[t];
		for (t = 16; t < 64; t++) begin
			s0 = rotr(sched_w[t-15], 7) ^ rotr(sched_w[t-15], 18) ^ (sched_w[t-15] >> 3);
			s1 = rotr(sched_w[t-2], 17) ^ rotr(sched_w[t-2], 19) ^ (sched_w[t-2] >> 10);
			sched_w[t] = sched_w[t-16] + s0 + sched_w[t-7] + s1;
		end
		a = run_hash[0]; b = run_hash[1]; c = run_hash[2]; d = run_hash[3];
		e = run_hash[4]; f = run_hash[5]; g = run_hash[6]; h = run_hash[7];
		for (t = 0; t < 64; t++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[t] + sched_w[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
		run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
	endfunction

	// Pack one byte big-endian into the block, compress on a full block
	function automatic void sha_take_byte(input logic [7:0] bv);
		logic [3:0] wi;
		int sh;
		wi = msg_fill[5:2];
		sh = (3 - msg_fill[1:0]) * 8;
		if (msg_fill[1:0] == 2'd0)
			msg_block[wi] = {24'd0, bv} << sh;
		else
			msg_block[wi] |= {24'd0, bv} << sh;
		msg_fill = msg_fill + 6'd1;
		if (msg_fill == 6'd0)
			sha_round_block();
	endfunction

	function automatic void sha_restore();
		int i;
		for (i = 0; i < 8; i++)
			run_hash[i] = INIT_HASH[i];
		msg_fill = '0;
		msg_bits = '0;
	endfunction

	// Pad, append the bit length, compress, latch the digest, restart
	function automatic void sha_close_message();
		logic [63:0] len;
		int i;
		len = msg_bits;
		sha_take_byte(PAD_MARK);
		while (msg_fill != LEN_START)
			sha_take_byte(8'h00);
		msg_block[14] = len[63:32];
		msg_block[15] = len[31:0];
		msg_fill = '0;
		sha_round_block();
		for (i = 0; i < 8; i++)
			last_digest[i] = run_hash[i];
		sha_restore();
	endfunction

	// Advance the model on an accepted request and queue the digest words due
	task automatic model_request(input msg_request_t r);
		digest_word_t dw;
		int i;
		if (r.has_byte) begin
			sha_take_byte(r.data);
			msg_bits += 64'd8;
			n_bytes++;
			cur_len++;
		end else if (!r.end_mark) begin
			n_idle++;
		end
		if (r.end_mark) begin
			sha_close_message();
			for (i = 0; i < 8; i++) begin
				dw.value   = r.known ? r.digest[255 - 32*i -: 32] : last_digest[i];
				dw.pos     = i[2:0];
				dw.is_last = (i == 7);
				digest_words_due = {digest_words_due, dw};
			end
			n_messages++;
			if (cur_len > longest_msg)
				longest_msg = cur_len;
			cur_len = 0;
		end
	endtask

	task automatic idle_sender(input int n);
		s_tvalid <= 1'b0;
		tx_offering = 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one request, wait for the handshake, then maybe gap the burst
	task automatic send_request(input msg_request_t r);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= r.data;
		s_tuser  <= r.has_byte;
		s_tlast  <= r.end_mark;
		tx_offering = 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		model_request(r);
		tx_burst_left--;
		if (tx_burst_left <= 0) begin
			tx_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0)
				idle_sender(gap);
		end
	endtask

	// Stop offering and wait for every queued digest word
	task automatic drain_digests();
		if (tx_offering)
			idle_sender(1);
		while (digest_words_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Drive m_tready in segments of random mode, with one long hold-off on request
	initial begin : rx_stall_pattern
		int seg_left;
		int mode;
		int phase;
		m_tready = 1'b0;
		seg_left = 0;
		mode = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 120);
				end
				seg_left--;
				phase++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (phase % 4 == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Compare each accepted digest word with the oldest one due
	always @(posedge clk) begin : digest_check
		digest_word_t due;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			words_seen++;
			if (digest_words_due.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected digest word %h index %0d last %0b", $time,
					m_tdata[31:0], m_tdata[34:32], m_tlast);
			end else begin
				due = digest_words_due.pop_front();
				if (m_tdata[31:0] !== due.value || m_tdata[34:32] !== due.pos
						|| m_tlast !== due.is_last) begin
					fail_count++;
					$display("%0t: expected %h index %0d last %0b, got %h index %0d last %0b",
						$time, due.value, due.pos, due.is_last,
						m_tdata[31:0], m_tdata[34:32], m_tlast);
				end
			end
		end
	end

	// Bound the run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d digest words still due", $time,
				cycle_count, digest_words_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		msg_request_t row;
		int r;
		int len;
		int k;
		int msg_no;
		int random_items;
		bit end_on_byte;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		tx_offering = 1'b0;
		rx_hold_req = 1'b0;
		tx_burst_left = 1;
		fail_count = 0;
		cycle_count = 0;
		words_seen = 0;
		n_messages = 0;
		n_bytes = 0;
		n_idle = 0;
		cur_len = 0;
		longest_msg = 0;
		random_items = 0;
		msg_no = 0;
		sha_restore();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the directed table
		for (r = 0; r < DIRECTED_N; r++)
			send_request(DIRECTED_ROWS[r]);
		drain_digests();

		// Random messages, lengths biased toward padding boundaries
		row.known = 1'b0;
		row.digest = '0;
		while (random_items < RANDOM_ITEMS) begin
			if (msg_no == 3) begin
				rx_hold_req = 1'b1;
				len = 1;
			end else if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = 55;
					2: len = 56;
					3: len = 57;
					4: len = 63;
					5: len = 64;
					6: len = 65;
					7: len = 119;
					8: len = 120;
					default: len = 128;
				endcase
			end else begin
				len = $urandom_range(0, 24);
			end
			if (msg_no == 8)
				drain_digests();
			end_on_byte = (len > 0) && $urandom_range(0, 1);
			for (k = 0; k < len; k++) begin
				// Sprinkle ignored requests as noise
				if ($urandom_range(0, 9) == 0) begin
					row.data = 8'($urandom_range(0, 255));
					row.has_byte = 1'b0;
					row.end_mark = 1'b0;
					send_request(row);
				end
				row.data = 8'($urandom_range(0, 255));
				row.has_byte = 1'b1;
				row.end_mark = end_on_byte && (k == len - 1);
				send_request(row);
				random_items++;
			end
			if (!end_on_byte) begin
				row.data = 8'($urandom_range(0, 255));
				row.has_byte = 1'b0;
				row.end_mark = 1'b1;
				send_request(row);
				random_items++;
			end
			msg_no++;
		end
		drain_digests();

		$display("Covered %0d messages, %0d bytes, %0d ignored requests, longest %0d bytes",
			n_messages, n_bytes, n_idle, longest_msg);
		$display("Compared %0d digest words in %0d cycles, %0d mismatches",
			words_seen, cycle_count, fail_count);
		if (fail_count == 0 && digest_words_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
